[rtl/core/adc_pkg.sv]
// shared types and constants of the ascii decimal calculator
// no dependencies; imported by the controller, the datapath and the top level
package adc_pkg;

    localparam int VALUE_BITS  = 47;
    localparam int RESULT_BITS = 48;
    localparam int DIVSR_BITS  = 50;   // holds ten to the fifteenth

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_BAD_A = 3'd1;
    localparam logic [2:0] ST_BAD_B = 3'd2;
    localparam logic [2:0] ST_NO_OP = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;

    typedef enum logic [2:0] {
        P_A_INT, P_A_FRAC, P_A_SKIP, P_B_INT, P_B_FRAC, P_B_SKIP
    } t_phase;

    typedef enum logic [3:0] {
        S_PARSE, S_LOAD_A, S_RUN_A, S_LOAD_B, S_RUN_B,
        S_DECIDE, S_LOAD_OP, S_RUN_OP, S_OUT
    } t_state;

    typedef struct packed {
        logic parse;
        logic start_a;
        logic start_b;
        logic start_op;
        logic run;
        logic save_a;
        logic save_b;
        logic save_op;
        logic decide;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic term;
        logic unit_done;
        logic need_unit;
        logic out_free;
    } t_stat;

    // ten to the power k
    function automatic logic [DIVSR_BITS-1:0] pow10(input logic [3:0] k);
        logic [DIVSR_BITS-1:0] p;
        case (k)
            4'd0:    p = 50'd1;
            4'd1:    p = 50'd10;
            4'd2:    p = 50'd100;
            4'd3:    p = 50'd1000;
            4'd4:    p = 50'd10000;
            4'd5:    p = 50'd100000;
            4'd6:    p = 50'd1000000;
            4'd7:    p = 50'd10000000;
            4'd8:    p = 50'd100000000;
            4'd9:    p = 50'd1000000000;
            4'd10:   p = 50'd10000000000;
            4'd11:   p = 50'd100000000000;
            4'd12:   p = 50'd1000000000000;
            4'd13:   p = 50'd10000000000000;
            4'd14:   p = 50'd100000000000000;
            default: p = 50'd1000000000000000;
        endcase
        return p;
    endfunction

endpackage

[rtl/core/adc_ctrl.sv]
// sequencing state machine of the calculator
// depends on adc_pkg for the state, command and status types
module adc_ctrl import adc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_PARSE:   if (i_valid && i_stat.term) n_state = S_LOAD_A;
            S_LOAD_A:  n_state = S_RUN_A;
            S_RUN_A:   if (i_stat.unit_done) n_state = S_LOAD_B;
            S_LOAD_B:  n_state = S_RUN_B;
            S_RUN_B:   if (i_stat.unit_done) n_state = S_DECIDE;
            S_DECIDE:  n_state = i_stat.need_unit ? S_LOAD_OP : S_OUT;
            S_LOAD_OP: n_state = S_RUN_OP;
            S_RUN_OP:  if (i_stat.unit_done) n_state = S_OUT;
            S_OUT:     if (i_stat.out_free) n_state = S_PARSE;
            default:   n_state = S_PARSE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_PARSE: begin
                o_ready     = 1'b1;
                o_cmd.parse = i_valid;
            end
            S_LOAD_A:  o_cmd.start_a = 1'b1;
            S_RUN_A: begin
                o_cmd.run    = 1'b1;
                o_cmd.save_a = i_stat.unit_done;
            end
            S_LOAD_B:  o_cmd.start_b = 1'b1;
            S_RUN_B: begin
                o_cmd.run    = 1'b1;
                o_cmd.save_b = i_stat.unit_done;
            end
            S_DECIDE:  o_cmd.decide = 1'b1;
            S_LOAD_OP: o_cmd.start_op = 1'b1;
            S_RUN_OP: begin
                o_cmd.run     = 1'b1;
                o_cmd.save_op = i_stat.unit_done;
            end
            S_OUT:     o_cmd.load_out = i_stat.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

[rtl/core/adc_dpath.sv]
// parser registers, shared serial divider and multiplier, output register
// depends on adc_pkg; driven by adc_ctrl through t_cmd and t_stat
module adc_dpath import adc_pkg::*; #(
    parameter int FRAC_BITS       = 16,
    parameter int MANTISSA_BITS   = 48,
    parameter int MAX_FRAC_DIGITS = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [7:0]                    i_ch,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [RESULT_BITS-1:0] o_result,
    output logic [VALUE_BITS-1:0]         o_first_value,
    output logic [VALUE_BITS-1:0]         o_second_value,
    output logic [1:0]                    o_op_code,
    output logic [2:0]                    o_status
);

    localparam int MB  = MANTISSA_BITS;
    localparam int VB  = VALUE_BITS;
    localparam int DW  = ((MB > VB) ? MB : VB) + FRAC_BITS;
    localparam int DVW = DIVSR_BITS;
    localparam int AW  = 2 * VB;
    localparam int CW  = $clog2(DW + 1);
    localparam logic [VB-1:0] VALUE_MAX = {VB{1'b1}};

    // parse state
    t_phase          r_phase;
    logic [MB-1:0]   r_ma, r_mb;
    logic [3:0]      r_ka, r_kb;
    logic [2:0]      r_op_seen;
    logic [1:0]      r_err;

    // arithmetic unit
    logic [DW-1:0]   r_quot;
    logic [DVW:0]    r_rem;
    logic [DVW-1:0]  r_div;
    logic [AW-1:0]   r_acc;
    logic [VB-1:0]   r_bsh;
    logic            r_is_mul;
    logic [CW-1:0]   r_cnt;
    logic [VB-1:0]   r_a, r_b;
    logic [RESULT_BITS-1:0] r_res;
    logic [2:0]      r_stat;
    logic [1:0]      r_op;

    // output register
    logic            r_o_valid;
    logic [RESULT_BITS-1:0] r_o_res;
    logic [VB-1:0]   r_o_a, r_o_b;
    logic [1:0]      r_o_op;
    logic [2:0]      r_o_stat;

    // character decode
    logic            is_digit, is_op, sel_b, frac, skip_add;
    logic [3:0]      dig;
    logic [1:0]      ch_op;
    logic [MB-1:0]   cur_m, new_m;
    logic [3:0]      cur_k, new_k;
    logic [MB+3:0]   prod;

    always_comb begin
        is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        dig      = is_digit ? 4'(i_ch - CH_ZERO) : 4'd0;
        is_op    = 1'b1;
        ch_op    = OP_ADD;
        case (i_ch)
            CH_PLUS:  ch_op = OP_ADD;
            CH_MINUS: ch_op = OP_SUB;
            CH_TIMES: ch_op = OP_MUL;
            CH_SLASH: ch_op = OP_DIV;
            default:  is_op = 1'b0;
        endcase
        sel_b    = (r_phase == P_B_INT) || (r_phase == P_B_FRAC) || (r_phase == P_B_SKIP);
        frac     = (r_phase == P_A_FRAC) || (r_phase == P_B_FRAC);
        cur_m    = sel_b ? r_mb : r_ma;
        cur_k    = sel_b ? r_kb : r_ka;
        // times ten as two shifts and an add
        prod     = {cur_m, 3'b000} + {2'b00, cur_m, 1'b0} + (MB+4)'(dig);
        skip_add = frac && (cur_k >= 4'(MAX_FRAC_DIGITS));
        new_m    = cur_m;
        new_k    = cur_k;
        if (!skip_add) begin
            if (|prod[MB+3:MB]) begin
                if (!frac) new_m = {MB{1'b1}};
            end else begin
                new_m = prod[MB-1:0];
                if (frac) new_k = cur_k + 4'd1;
            end
        end
    end

    // decision values
    logic [1:0]             op_code;
    logic [2:0]             n_stat;
    logic [RESULT_BITS-1:0] n_res;
    logic [RESULT_BITS-1:0] sum, dif;

    always_comb begin
        op_code = (r_op_seen == 3'd0) ? OP_ADD : 2'(r_op_seen - 3'd1);
        if (r_err[0])                          n_stat = ST_BAD_A;
        else if (r_err[1])                     n_stat = ST_BAD_B;
        else if (r_op_seen == 3'd0)            n_stat = ST_NO_OP;
        else if (op_code == OP_DIV && r_b == '0) n_stat = ST_DIV0;
        else                                   n_stat = ST_OK;
        sum = {1'b0, r_a} + {1'b0, r_b};
        dif = {1'b0, r_a} - {1'b0, r_b};
        n_res = '0;
        if (n_stat == ST_OK) begin
            case (op_code)
                OP_ADD:  n_res = sum[VB] ? {1'b0, VALUE_MAX} : sum;
                OP_SUB:  n_res = dif;
                default: n_res = '0;
            endcase
        end
    end

    // serial divider step and saturation
    logic [DVW:0]  rem_sh;
    logic          ge;
    logic [VB-1:0] quot_sat, mul_sat;

    always_comb begin
        rem_sh   = {r_rem[DVW-1:0], r_quot[DW-1]};
        ge       = rem_sh >= {1'b0, r_div};
        quot_sat = (|r_quot[DW-1:VB]) ? VALUE_MAX : r_quot[VB-1:0];
        mul_sat  = (|r_acc[AW-1:VB+FRAC_BITS]) ? VALUE_MAX : r_acc[VB+FRAC_BITS-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= P_A_INT;
            r_ma      <= '0;
            r_mb      <= '0;
            r_ka      <= '0;
            r_kb      <= '0;
            r_op_seen <= '0;
            r_err     <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.parse && i_ch != CH_NUL) begin
                if (!sel_b && is_op) begin
                    r_op_seen <= {1'b0, ch_op} + 3'd1;
                    r_phase   <= P_B_INT;
                end else if (r_phase == P_A_INT || r_phase == P_B_INT) begin
                    if (is_digit) begin
                        if (sel_b) r_mb <= new_m; else r_ma <= new_m;
                    end else if (i_ch == CH_DOT) begin
                        r_phase <= sel_b ? P_B_FRAC : P_A_FRAC;
                    end else begin
                        r_err   <= r_err | (sel_b ? 2'b10 : 2'b01);
                        r_phase <= sel_b ? P_B_SKIP : P_A_SKIP;
                    end
                end else if (frac) begin
                    if (is_digit) begin
                        if (sel_b) begin
                            r_mb <= new_m;
                            r_kb <= new_k;
                        end else begin
                            r_ma <= new_m;
                            r_ka <= new_k;
                        end
                    end else begin
                        r_phase <= sel_b ? P_B_SKIP : P_A_SKIP;
                    end
                end
            end
            if (i_cmd.start_a || i_cmd.start_b || i_cmd.start_op) begin
                r_cnt <= (i_cmd.start_op && op_code == OP_MUL) ? CW'(VB) : CW'(DW);
            end else if (i_cmd.run && r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
                r_phase   <= P_A_INT;
                r_ma      <= '0;
                r_mb      <= '0;
                r_ka      <= '0;
                r_kb      <= '0;
                r_op_seen <= '0;
                r_err     <= '0;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // arithmetic payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_a || i_cmd.start_b) begin
            r_quot   <= DW'({(i_cmd.start_b ? r_mb : r_ma), {FRAC_BITS{1'b0}}});
            r_div    <= pow10(i_cmd.start_b ? r_kb : r_ka);
            r_rem    <= '0;
            r_is_mul <= 1'b0;
        end else if (i_cmd.start_op) begin
            r_quot   <= DW'({r_a, {FRAC_BITS{1'b0}}});
            r_div    <= DVW'(r_b);
            r_rem    <= '0;
            r_acc    <= '0;
            r_bsh    <= r_b;
            r_is_mul <= (op_code == OP_MUL);
        end else if (i_cmd.run && r_cnt != '0) begin
            if (r_is_mul) begin
                r_acc <= {r_acc[AW-2:0], 1'b0} + (r_bsh[VB-1] ? AW'(r_a) : AW'(0));
                r_bsh <= {r_bsh[VB-2:0], 1'b0};
            end else begin
                r_rem  <= ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
                r_quot <= {r_quot[DW-2:0], ge};
            end
        end
        if (i_cmd.save_a) r_a <= quot_sat;
        if (i_cmd.save_b) r_b <= quot_sat;
        if (i_cmd.decide) begin
            r_res  <= n_res;
            r_stat <= n_stat;
            r_op   <= op_code;
        end
        if (i_cmd.save_op) r_res <= {1'b0, (r_is_mul ? mul_sat : quot_sat)};
        if (i_cmd.load_out) begin
            r_o_res  <= r_res;
            r_o_a    <= r_a;
            r_o_b    <= r_b;
            r_o_op   <= r_op;
            r_o_stat <= r_stat;
        end
    end

    always_comb begin
        o_stat.term      = (i_ch == CH_NUL);
        o_stat.unit_done = (r_cnt == '0);
        o_stat.need_unit = (n_stat == ST_OK) && (op_code == OP_MUL || op_code == OP_DIV);
        o_stat.out_free  = !r_o_valid || i_ready;
    end

    assign o_valid        = r_o_valid;
    assign o_result       = r_o_res;
    assign o_first_value  = r_o_a;
    assign o_second_value = r_o_b;
    assign o_op_code      = r_o_op;
    assign o_status       = r_o_stat;

endmodule

[rtl/core/ascii_decimal_calculator_unit.sv]
// top level of the ascii decimal calculator: controller plus datapath
// depends on adc_pkg, adc_ctrl and adc_dpath
//
// Takes an expression "A op B" one ASCII character per beat, ended by a zero
// byte, and gives one result beat per expression: both operands and A op B in
// fixed point with FRAC_BITS fraction bits, truncated and saturated, plus the
// operator code and a status. Every non-terminator character is taken as soon
// as it is offered. The terminator starts the evaluation, during which no
// character is taken: each operand is loaded and then goes through a
// one-bit-a-cycle restoring divider that scales it by its power of ten, then
// times uses a one-bit-a-cycle shift-add multiplier and divide runs the same
// divider again. The result register lets the next expression be read while a
// result waits.
module ascii_decimal_calculator_unit import adc_pkg::*; #(
    parameter int FRAC_BITS       = 16,
    parameter int MANTISSA_BITS   = 48,
    parameter int MAX_FRAC_DIGITS = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // character channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_ch,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [RESULT_BITS-1:0] o_result,
    output logic [VALUE_BITS-1:0]         o_first_value,
    output logic [VALUE_BITS-1:0]         o_second_value,
    output logic [1:0]                    o_op_code,
    output logic [2:0]                    o_status
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing: parse, scale a, scale b, decide, optional mul or div, output
    adc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // parser registers, serial arithmetic and the result register
    adc_dpath #(
        .FRAC_BITS       (FRAC_BITS),
        .MANTISSA_BITS   (MANTISSA_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ch           (i_ch),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result       (o_result),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_op_code      (o_op_code),
        .o_status       (o_status)
    );

endmodule
